/* hw/rtl/peq_pkg.sv */
// peq_pkg: shared constants, types and helpers for the priority event queues.
// No dependencies; every other file takes names from here by scope.
`default_nettype none
package peq_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int RING_DEPTH  = 16;
  localparam int EVENT_WIDTH = 32;

  localparam int OWNER_REGS = 8;
  localparam int OWNER_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int PID_W      = 7;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;

  localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RING_W  = $clog2(NUM_SLOTS + 1);
  localparam int ADDR_W  = RING_W + PTR_W;
  localparam int MEM_DEPTH = (NUM_SLOTS + 1) * (2 ** PTR_W);

  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [SLOT_W-1:0]      slot_idx_t;
  typedef logic [RING_W-1:0]      ring_idx_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [EVENT_WIDTH-1:0] event_t;
  typedef logic signed [OWNER_W-1:0] owner_t;

  localparam ring_idx_t CONSOLE_RING = '0;

  typedef enum logic [OP_W-1:0] {
    OP_CONSOLE_PUSH = 2'd0,
    OP_PROC_PUSH    = 2'd1,
    OP_POLL         = 2'd2,
    OP_NONE         = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED = 3'd0,
    ST_FULL   = 3'd1,
    ST_NOSLOT = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_EVENT  = 3'd4,
    ST_LOST   = 3'd5
  } status_t;

  // One access to the ring store per item.
  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    addr_t  addr;
    event_t wdata;
  } mem_req_t;

  // Outcome of one item as decided at its transfer.
  typedef struct packed {
    status_t status;
    logic    has_data;
  } result_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_inc = (p == ptr_t'(RING_DEPTH - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
  endfunction

  function automatic logic ring_full(ptr_t head, ptr_t tail);
    logic [PTR_W:0] diff;
    if (head >= tail) begin
      diff = {1'b0, head} - {1'b0, tail};
    end else begin
      diff = {1'b0, head} + (PTR_W+1)'(RING_DEPTH) - {1'b0, tail};
    end
    ring_full = (diff == (PTR_W+1)'(RING_DEPTH - 1));
  endfunction

  function automatic addr_t ring_addr(ring_idx_t r, ptr_t p);
    ring_addr = {r, p};
  endfunction

  function automatic owner_t owner_reset(int i);
    owner_reset = (i == 0) ? owner_t'(0) : owner_t'(-1);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/peq_ifs.sv */
// peq_in_if / peq_out_if: valid-ready channels for items and results.
// Depends on peq_pkg for payload widths.
`default_nettype none
interface peq_in_if;
  logic                        valid;
  logic                        ready;
  logic [peq_pkg::OP_W-1:0]    operation;
  logic [peq_pkg::PID_W-1:0]   process_id;
  peq_pkg::event_t             event_data;

  modport source (output valid, operation, process_id, event_data, input ready);
  modport sink   (input valid, operation, process_id, event_data, output ready);
endinterface

interface peq_out_if;
  logic                          valid;
  logic                          ready;
  logic [peq_pkg::STATUS_W-1:0]  status;
  peq_pkg::event_t               event_out;

  modport source (output valid, status, event_out, input ready);
  modport sink   (input valid, status, event_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/priority_event_queues_with_loss_flag_core.sv */
// Priority event queues with a sticky loss flag: console ring plus per-slot rings.
// The ring store reads and the pending register takes the decision at the input
// transfer; the output register loads the result once it is free or draining.
// A new item is taken only once the last has moved to the output register, as its
// read data waits in the single ring store port; a stalled result holds off the input.
// Synchronous reset clears pointers, lost flags and handshake state, loads owner defaults.
`default_nettype none
module priority_event_queues_with_loss_flag_core (
  input  wire                           clk,
  input  wire                           rst,
  peq_in_if.sink                        in_ch,
  peq_out_if.source                     out_ch,
  input  wire                           cfg_we,
  input  wire [peq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [peq_pkg::OWNER_W-1:0]    cfg_data
);

  logic               accept;
  peq_pkg::mem_req_t  req;
  peq_pkg::result_t   res;
  peq_pkg::event_t    rdata;

  // Item in flight between its transfer and the output register.
  logic               pend;
  peq_pkg::result_t   pend_res;

  logic               out_valid;
  peq_pkg::status_t   out_status;
  peq_pkg::event_t    out_event;
  logic               out_load;

  // Take a new item only once the previous one has left the decide stage;
  // hold the input off during reset.
  assign in_ch.ready = !pend && !rst;
  assign accept      = in_ch.valid && in_ch.ready;

  // Move the pending result forward when the output register is free or draining.
  assign out_load = pend && (!out_valid || out_ch.ready);

  peq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (in_ch.operation),
    .process_id (in_ch.process_id),
    .event_data (in_ch.event_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req),
    .res        (res)
  );

  peq_ring_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Control: pend and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (out_load) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold decision; read data stays in the store's register while pending.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_res <= res;
    end
    if (out_load) begin
      out_status <= pend_res.status;
      out_event  <= pend_res.has_data ? rdata : '0;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.event_out = out_event;

endmodule
`default_nettype wire

/* hw/rtl/peq_ring_mem.sv */
// peq_ring_mem: single-port synchronous store for all ring entries.
// Depends on peq_pkg; registered read, read data held between reads.
`default_nettype none
module peq_ring_mem (
  input  wire              clk,
  input  peq_pkg::mem_req_t req,
  output peq_pkg::event_t  rdata
);

  peq_pkg::event_t mem [peq_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/peq_ctrl.sv */
// peq_ctrl: owner registers, ring pointers and lost flags; decides each item.
// Depends on peq_pkg; drives the access to peq_ring_mem.
`default_nettype none
module peq_ctrl (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             accept,
  input  wire [peq_pkg::OP_W-1:0]         operation,
  input  wire [peq_pkg::PID_W-1:0]        process_id,
  input  peq_pkg::event_t                 event_data,
  input  wire                             cfg_we,
  input  wire [peq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [peq_pkg::OWNER_W-1:0]      cfg_data,
  output peq_pkg::mem_req_t               req,
  output peq_pkg::result_t                res
);

  peq_pkg::owner_t owner [peq_pkg::NUM_SLOTS];

  peq_pkg::ptr_t con_head, con_tail;
  logic          con_lost;
  peq_pkg::ptr_t slot_head [peq_pkg::NUM_SLOTS];
  peq_pkg::ptr_t slot_tail [peq_pkg::NUM_SLOTS];
  logic          slot_lost [peq_pkg::NUM_SLOTS];

  logic              hit;
  peq_pkg::slot_idx_t sel;

  peq_pkg::ptr_t con_head_next, con_tail_next;
  logic          con_lost_next;
  peq_pkg::ptr_t sel_head_next, sel_tail_next;
  logic          sel_lost_next;
  logic          slot_upd;

  peq_pkg::op_t  op;
  peq_pkg::owner_t pid_s;

  assign op    = peq_pkg::op_t'(operation);
  assign pid_s = peq_pkg::owner_t'({1'b0, process_id});

  // Lowest numbered matching slot wins.
  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int i = peq_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (owner[i] == pid_s) begin
        hit = 1'b1;
        sel = peq_pkg::slot_idx_t'(i);
      end
    end
  end

  always_comb begin
    peq_pkg::ptr_t sh, st;
    logic          sl;
    sh = slot_head[sel];
    st = slot_tail[sel];
    sl = slot_lost[sel];

    con_head_next = con_head;
    con_tail_next = con_tail;
    con_lost_next = con_lost;
    sel_head_next = sh;
    sel_tail_next = st;
    sel_lost_next = sl;
    slot_upd      = 1'b0;
    req           = '0;
    req.wdata     = event_data;
    res.status    = peq_pkg::ST_EMPTY;
    res.has_data  = 1'b0;

    case (op)
      peq_pkg::OP_CONSOLE_PUSH: begin
        if (peq_pkg::ring_full(con_head, con_tail)) begin
          con_lost_next = 1'b1;
          res.status    = peq_pkg::ST_FULL;
        end else begin
          req.wr_en     = 1'b1;
          req.addr      = peq_pkg::ring_addr(peq_pkg::CONSOLE_RING, con_head);
          con_head_next = peq_pkg::ptr_inc(con_head);
          res.status    = peq_pkg::ST_QUEUED;
        end
      end
      peq_pkg::OP_PROC_PUSH: begin
        if (!hit) begin
          res.status = peq_pkg::ST_NOSLOT;
        end else if (peq_pkg::ring_full(sh, st)) begin
          slot_upd      = 1'b1;
          sel_lost_next = 1'b1;
          res.status    = peq_pkg::ST_FULL;
        end else begin
          slot_upd      = 1'b1;
          req.wr_en     = 1'b1;
          req.addr      = peq_pkg::ring_addr(
                            peq_pkg::ring_idx_t'(sel) + peq_pkg::ring_idx_t'(1), sh);
          sel_head_next = peq_pkg::ptr_inc(sh);
          res.status    = peq_pkg::ST_QUEUED;
        end
      end
      peq_pkg::OP_POLL: begin
        if (con_lost) begin
          con_lost_next = 1'b0;
          res.status    = peq_pkg::ST_LOST;
        end else if (con_head != con_tail) begin
          req.rd_en     = 1'b1;
          req.addr      = peq_pkg::ring_addr(peq_pkg::CONSOLE_RING, con_tail);
          con_tail_next = peq_pkg::ptr_inc(con_tail);
          res.status    = peq_pkg::ST_EVENT;
          res.has_data  = 1'b1;
        end else if (!hit) begin
          res.status = peq_pkg::ST_NOSLOT;
        end else if (sl) begin
          slot_upd      = 1'b1;
          sel_lost_next = 1'b0;
          res.status    = peq_pkg::ST_LOST;
        end else if (sh != st) begin
          slot_upd      = 1'b1;
          req.rd_en     = 1'b1;
          req.addr      = peq_pkg::ring_addr(
                            peq_pkg::ring_idx_t'(sel) + peq_pkg::ring_idx_t'(1), st);
          sel_tail_next = peq_pkg::ptr_inc(st);
          res.status    = peq_pkg::ST_EVENT;
          res.has_data  = 1'b1;
        end else begin
          res.status = peq_pkg::ST_EMPTY;
        end
      end
      default: begin
        res.status = peq_pkg::ST_EMPTY;
      end
    endcase

    if (!accept) begin
      req.wr_en = 1'b0;
      req.rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      con_head <= '0;
      con_tail <= '0;
      con_lost <= 1'b0;
      for (int i = 0; i < peq_pkg::NUM_SLOTS; i++) begin
        slot_head[i] <= '0;
        slot_tail[i] <= '0;
        slot_lost[i] <= 1'b0;
        owner[i]     <= peq_pkg::owner_reset(i);
      end
    end else begin
      if (accept) begin
        con_head <= con_head_next;
        con_tail <= con_tail_next;
        con_lost <= con_lost_next;
        if (slot_upd) begin
          slot_head[sel] <= sel_head_next;
          slot_tail[sel] <= sel_tail_next;
          slot_lost[sel] <= sel_lost_next;
        end
      end
      for (int i = 0; i < peq_pkg::NUM_SLOTS; i++) begin
        if (cfg_we && (cfg_index == peq_pkg::CFG_IDX_W'(i))) begin
          owner[i] <= peq_pkg::owner_t'(cfg_data);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/peq_checker.sv */
// peq_checker: port-level assertions for the priority event queue core.
// Depends on peq_pkg; bound to priority_event_queues_with_loss_flag_core below.
`default_nettype none
module peq_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [peq_pkg::STATUS_W-1:0]  status,
  input peq_pkg::event_t              event_out
);

  // A result stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // Payload is zero unless an event is returned.
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != peq_pkg::ST_EVENT) |-> (event_out == '0))
    else $error("nonzero event_out without event status");

  // Only defined status codes leave the block.
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= peq_pkg::ST_LOST))
    else $error("undefined status code");

  // Items are taken one at a time: no transfer right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input transfer while an item is in flight");

endmodule

bind priority_event_queues_with_loss_flag_core peq_checker u_peq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .event_out (out_ch.event_out)
);
`default_nettype wire
